FILE: hdl/tdec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle depth/elevation converter.
// No dependencies; every other file of the block uses this package.
package tdec_pkg;

  // Word and intermediate widths.
  localparam int WORD_BITS   = 32;
  localparam int THR_W       = 16;
  localparam int NUM_W       = 3 * WORD_BITS;
  localparam int DEN_W       = 2 * WORD_BITS + 2;
  localparam int QUO_W       = WORD_BITS + 3;
  localparam int CBRT_W      = WORD_BITS;
  localparam int SQRT_W      = WORD_BITS + 2;
  localparam int ITER_STAGES = QUO_W;
  localparam int SAT_W       = WORD_BITS + 6;

  // Command codes.
  localparam logic CMD_D2E = 1'b0;
  localparam logic CMD_E2D = 1'b1;

  typedef enum logic [1:0] {
    REG_DRY = 2'd0,
    REG_LOW = 2'd1,
    REG_MID = 2'd2,
    REG_WET = 2'd3
  } region_t;

  // Item context that rides along the iterative stages.
  typedef struct packed {
    logic                 cmd;
    region_t              region;
    logic                 neg;
    logic [WORD_BITS-1:0] z1;
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] d21;
    logic [WORD_BITS-1:0] d31;
  } side_t;

  // State of divider, cube root and square root at one stage.
  typedef struct packed {
    logic [NUM_W-1:0]      rem;
    logic [DEN_W-1:0]      den;
    logic [QUO_W-1:0]      quo;
    logic [3*CBRT_W-1:0]   c_arg;
    logic [CBRT_W-1:0]     c_root;
    logic [2*CBRT_W-1:0]   c_sq;
    logic [3*CBRT_W-1:0]   c_cube;
    logic [2*SQRT_W-1:0]   s_arg;
    logic [SQRT_W-1:0]     s_root;
    logic [2*SQRT_W-1:0]   s_sq;
    side_t                 side;
  } iter_t;

  // Saturate a wide signed value to the signed word.
  function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      sat_word = hi[WORD_BITS-1:0];
    end else if (x < lo) begin
      sat_word = lo[WORD_BITS-1:0];
    end else begin
      sat_word = x[WORD_BITS-1:0];
    end
  endfunction

endpackage

FILE: hdl/tdec_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter's input and result items.
// Depends on tdec_pkg for the word width.
interface tdec_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [tdec_pkg::WORD_BITS-1:0] value_in;
  logic signed [tdec_pkg::WORD_BITS-1:0] z_low;
  logic signed [tdec_pkg::WORD_BITS-1:0] z_mid;
  logic signed [tdec_pkg::WORD_BITS-1:0] z_high;
  modport source (output valid, command, value_in, z_low, z_mid, z_high, input ready);
  modport sink (input valid, command, value_in, z_low, z_mid, z_high, output ready);
endinterface

interface tdec_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tdec_pkg::WORD_BITS-1:0] value_out;
  logic [1:0]                          region;
  modport source (output valid, value_out, region, input ready);
  modport sink (input valid, value_out, region, output ready);
endinterface

FILE: hdl/tdec_iter_stage.sv
`timescale 1ns / 1ps
// One registered step of the restoring divider, cube root and square root.
// Depends on tdec_pkg for the stage record and widths.
module tdec_iter_stage #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  tdec_pkg::iter_t d_in,
  output tdec_pkg::iter_t d_out
);

  localparam int NW    = tdec_pkg::NUM_W;
  localparam int QW    = tdec_pkg::QUO_W;
  localparam int CW    = tdec_pkg::CBRT_W;
  localparam int SW    = tdec_pkg::SQRT_W;
  localparam int CMP_W = tdec_pkg::DEN_W + QW;
  localparam int CUB_W = 3 * CW + 4;
  localparam int CSQ_W = 2 * CW + 2;
  localparam int SSQ_W = 2 * SW + 2;
  localparam int QB    = QW - 1 - STEP;
  localparam bit DO_CUBE = (STEP < CW);
  localparam int CB    = DO_CUBE ? (CW - 1 - STEP) : 0;
  localparam bit DO_SQRT = (STEP < SW);
  localparam int SB    = DO_SQRT ? (SW - 1 - STEP) : 0;

  tdec_pkg::iter_t  nxt;
  tdec_pkg::iter_t  stage_r;
  logic [CMP_W-1:0] den_sh;
  logic [CMP_W-1:0] rem_x;
  logic [CUB_W-1:0] term_a;
  logic [CUB_W-1:0] term_b;
  logic [CUB_W-1:0] cube_try;
  logic [CSQ_W-1:0] csq_try;
  logic [SSQ_W-1:0] ssq_try;

  // Trial values for this bit of each unit.
  always_comb begin
    den_sh   = CMP_W'(d_in.den) << QB;
    rem_x    = CMP_W'(d_in.rem);
    term_a   = CUB_W'(d_in.c_sq) << CB;
    term_b   = CUB_W'(d_in.c_root) << (2 * CB);
    cube_try = CUB_W'(d_in.c_cube) + term_a + (term_a << 1) + term_b + (term_b << 1)
             + (CUB_W'(1) << (3 * CB));
    csq_try  = CSQ_W'(d_in.c_sq) + (CSQ_W'(d_in.c_root) << (CB + 1))
             + (CSQ_W'(1) << (2 * CB));
    ssq_try  = SSQ_W'(d_in.s_sq) + (SSQ_W'(d_in.s_root) << (SB + 1))
             + (SSQ_W'(1) << (2 * SB));
  end

  // Accept each trial bit that keeps the partial result in range.
  always_comb begin
    nxt = d_in;
    if (rem_x >= den_sh) begin
      nxt.rem     = NW'(rem_x - den_sh);
      nxt.quo[QB] = 1'b1;
    end
    if (DO_CUBE && (cube_try <= CUB_W'(d_in.c_arg))) begin
      nxt.c_root = d_in.c_root | (CW'(1) << CB);
      nxt.c_sq   = (2 * CW)'(csq_try);
      nxt.c_cube = (3 * CW)'(cube_try);
    end
    if (DO_SQRT && (ssq_try <= SSQ_W'(d_in.s_arg))) begin
      nxt.s_root = d_in.s_root | (SW'(1) << SB);
      nxt.s_sq   = (2 * SW)'(ssq_try);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= nxt;
    end
  end

  assign d_out = stage_r;

endmodule

FILE: hdl/triangle_depth_elevation_convert_unit.sv
`timescale 1ns / 1ps
// Top level of the triangle cell depth/free-surface converter.
// Depends on tdec_pkg, tdec_if and tdec_iter_stage.

// The unit takes one cell per clock while the skid register is empty: five
// stages sort the vertices, form the products and pick the region, 35 stages
// run the restoring divider (one quotient bit each) with the cube root and
// square root beside it, and one stage saturates and forms the result. The
// pipeline moves as a whole; a two-entry output with a skid register lets it
// keep taking items while one result waits, and input ready drops only while
// the skid register is full. dry_threshold must be written only while no item
// is in flight.
module triangle_depth_elevation_convert_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  tdec_in_if.sink                    in_ch,
  tdec_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [tdec_pkg::THR_W-1:0] cfg_wdata
);

  localparam int W   = tdec_pkg::WORD_BITS;
  localparam int NS  = tdec_pkg::ITER_STAGES;
  localparam int NST = NS + 6;
  localparam int SW  = tdec_pkg::SQRT_W;
  localparam int STW = tdec_pkg::SAT_W;

  // Configuration and handshake control.
  logic [tdec_pkg::THR_W-1:0] dry_thr_r;
  logic [NST-1:0]             vld_r;
  logic [NST-1:0]             vld_nxt;
  logic                       skid_full_r;
  logic                       skid_full_nxt;
  logic                       adv;
  logic                       in_fire;

  // Stage 1: sorted vertices.
  logic              p1_cmd_r;
  logic signed [W-1:0] p1_v_r, p1_z1_r, p1_z2_r, p1_z3_r;
  logic signed [W-1:0] srt_lo, srt_hi, srt_m, srt_top, srt_z1, srt_z2;

  // Stage 2: differences and flags.
  logic                  p2_cmd_r, p2_dry_r, p2_gt1_r, p2_gt2_r, p2_gt3_r;
  logic signed [W-1:0]   p2_v_r, p2_z1_r;
  logic [W-1:0]          p2_d21_r, p2_d31_r, p2_e_r;
  logic signed [W+1:0]   p2_sum_r;
  logic [W:0]            p2_h3_r;
  logic signed [W+3:0]   p2_x_r;
  logic signed [W+1:0]   sum_nxt;
  logic signed [W+3:0]   vx, x_nxt;
  logic [W:0]            h3_nxt;

  // Stage 3: first products.
  logic                  p3_cmd_r, p3_dry_r, p3_gt1_r, p3_gt2_r, p3_gt3_r;
  logic signed [W-1:0]   p3_v_r, p3_z1_r;
  logic [W-1:0]          p3_d21_r, p3_d31_r, p3_e_r;
  logic [2*W:0]          p3_lhs_r, p3_ph21_r, p3_pa_r;
  logic [2*W-1:0]        p3_sq21_r, p3_sq31_r, p3_p2131_r, p3_e2_r;
  logic [W+1:0]          p3_t_r, p3_d31x3_r;
  logic                  p3_cmp_ok_r, p3_neg3_r, p3_sneg_r;
  logic [W+2:0]          p3_ax_r;
  logic [W+1:0]          p3_asum_r;
  logic [W+1:0]          t_nxt;

  // Stage 4: region choice and second products.
  logic                  p4_cmd_r, p4_neg3_r, p4_sneg_r;
  tdec_pkg::region_t     p4_region_r, region_nxt;
  logic signed [W-1:0]   p4_v_r, p4_z1_r;
  logic [W-1:0]          p4_d21_r, p4_d31_r;
  logic [2*W:0]          p4_ca_hi_r, p4_num2_r;
  logic [2*W-1:0]        p4_ca_lo_r, p4_e3_hi_r, p4_e3_lo_r, p4_sq31_r;
  logic [tdec_pkg::DEN_W-1:0] p4_den1_r;
  logic [2*W+1:0]        p4_dp_r;
  logic [W+2:0]          p4_ax_r;
  logic [W+1:0]          p4_asum_r, p4_d31x3_r;
  logic                  r1_hit, r2_hit;

  // Stage 5 onward: iterative units.
  tdec_pkg::iter_t       it_s [0:NS];
  tdec_pkg::iter_t       p5_nxt;
  logic [3*W:0]          cube_full;
  logic [3*W:0]          e3_full;
  logic [2*SW:0]         disc_full;

  // Result stage and skid register.
  logic [W-1:0]          out_value_r, skid_value_r, res_nxt;
  tdec_pkg::region_t     out_region_r, skid_region_r;
  tdec_pkg::iter_t       last;
  logic signed [STW-1:0] q_signed;
  logic [W-1:0]          cr_clamp;
  logic [SW-1:0]         sq_s;

  assign adv         = !skid_full_r;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_thr_r <= tdec_pkg::THR_W'(1);
    end else if (cfg_we) begin
      dry_thr_r <= cfg_wdata;
    end
  end

  // Valid bits travel with the items; the skid register holds a stalled result.
  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[NST-2:0], in_fire};
    end
    skid_full_nxt = skid_full_r;
    if (skid_full_r) begin
      skid_full_nxt = !out_ch.ready;
    end else begin
      skid_full_nxt = vld_r[NST-1] && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      skid_full_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  // Stage 1: sort the three bed elevations ascending.
  always_comb begin
    srt_lo  = (in_ch.z_low > in_ch.z_mid) ? in_ch.z_mid : in_ch.z_low;
    srt_hi  = (in_ch.z_low > in_ch.z_mid) ? in_ch.z_low : in_ch.z_mid;
    srt_m   = (srt_hi > in_ch.z_high) ? in_ch.z_high : srt_hi;
    srt_top = (srt_hi > in_ch.z_high) ? srt_hi : in_ch.z_high;
    srt_z1  = (srt_lo > srt_m) ? srt_m : srt_lo;
    srt_z2  = (srt_lo > srt_m) ? srt_lo : srt_m;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cmd_r <= in_ch.command;
      p1_v_r   <= in_ch.value_in;
      p1_z1_r  <= srt_z1;
      p1_z2_r  <= srt_z2;
      p1_z3_r  <= srt_top;
    end
  end

  // Stage 2: differences, vertex sum, 3h and the region flags.
  always_comb begin
    sum_nxt = (W+2)'(p1_z1_r) + (W+2)'(p1_z2_r) + (W+2)'(p1_z3_r);
    h3_nxt  = ((W+1)'(p1_v_r[W-2:0]) << 1) + (W+1)'(p1_v_r[W-2:0]);
    vx      = (W+4)'(p1_v_r);
    x_nxt   = (vx <<< 1) + vx - (W+4)'(sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_cmd_r <= p1_cmd_r;
      p2_v_r   <= p1_v_r;
      p2_z1_r  <= p1_z1_r;
      p2_d21_r <= W'(p1_z2_r - p1_z1_r);
      p2_d31_r <= W'(p1_z3_r - p1_z1_r);
      p2_e_r   <= W'(p1_v_r - p1_z1_r);
      p2_sum_r <= sum_nxt;
      p2_h3_r  <= h3_nxt;
      p2_x_r   <= x_nxt;
      p2_dry_r <= p1_v_r <= $signed({{(W-tdec_pkg::THR_W){1'b0}}, dry_thr_r});
      p2_gt1_r <= p1_v_r > p1_z1_r;
      p2_gt2_r <= p1_v_r > p1_z2_r;
      p2_gt3_r <= p1_v_r > p1_z3_r;
    end
  end

  // Stage 3: the first row of products and the magnitudes for division by 3.
  assign t_nxt = (W+2)'(p2_d21_r) + (W+2)'(p2_h3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_cmd_r    <= p2_cmd_r;
      p3_dry_r    <= p2_dry_r;
      p3_gt1_r    <= p2_gt1_r;
      p3_gt2_r    <= p2_gt2_r;
      p3_gt3_r    <= p2_gt3_r;
      p3_v_r      <= p2_v_r;
      p3_z1_r     <= p2_z1_r;
      p3_d21_r    <= p2_d21_r;
      p3_d31_r    <= p2_d31_r;
      p3_e_r      <= p2_e_r;
      p3_lhs_r    <= (2*W+1)'(p2_h3_r) * (2*W+1)'(p2_d31_r);
      p3_ph21_r   <= (2*W+1)'(p2_h3_r) * (2*W+1)'(p2_d21_r);
      p3_pa_r     <= (2*W+1)'(p2_e_r) * ((2*W+1)'(p2_e_r) + (2*W+1)'(p2_d31_r));
      p3_sq21_r   <= (2*W)'(p2_d21_r) * (2*W)'(p2_d21_r);
      p3_sq31_r   <= (2*W)'(p2_d31_r) * (2*W)'(p2_d31_r);
      p3_p2131_r  <= (2*W)'(p2_d21_r) * (2*W)'(p2_d31_r);
      p3_e2_r     <= (2*W)'(p2_e_r) * (2*W)'(p2_e_r);
      p3_t_r      <= t_nxt;
      p3_cmp_ok_r <= t_nxt <= ((W+2)'(p2_d31_r) << 1);
      p3_d31x3_r  <= ((W+2)'(p2_d31_r) << 1) + (W+2)'(p2_d31_r);
      p3_neg3_r   <= p2_x_r[W+3];
      p3_ax_r     <= p2_x_r[W+3] ? (W+3)'(-p2_x_r) : (W+3)'(p2_x_r);
      p3_sneg_r   <= p2_sum_r[W+1];
      p3_asum_r   <= p2_sum_r[W+1] ? ((W+2)'(-p2_sum_r) + (W+2)'(2)) : (W+2)'(p2_sum_r);
    end
  end

  // Stage 4: decide the region and form the second row of products.
  always_comb begin
    r1_hit = (p3_d21_r != '0) && ((2*W+1)'(p3_lhs_r) <= (2*W+1)'(p3_sq21_r));
    r2_hit = ((2*W+1)'(p3_lhs_r) > (2*W+1)'(p3_sq21_r)) && p3_cmp_ok_r;
    if (p3_cmd_r == tdec_pkg::CMD_D2E) begin
      if (p3_dry_r) begin
        region_nxt = tdec_pkg::REG_DRY;
      end else if (r1_hit) begin
        region_nxt = tdec_pkg::REG_LOW;
      end else if (r2_hit) begin
        region_nxt = tdec_pkg::REG_MID;
      end else begin
        region_nxt = tdec_pkg::REG_WET;
      end
    end else begin
      if (p3_gt3_r) begin
        region_nxt = tdec_pkg::REG_WET;
      end else if (p3_gt2_r) begin
        region_nxt = tdec_pkg::REG_MID;
      end else if (p3_gt1_r) begin
        region_nxt = tdec_pkg::REG_LOW;
      end else begin
        region_nxt = tdec_pkg::REG_DRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_cmd_r    <= p3_cmd_r;
      p4_region_r <= region_nxt;
      p4_neg3_r   <= p3_neg3_r;
      p4_sneg_r   <= p3_sneg_r;
      p4_v_r      <= p3_v_r;
      p4_z1_r     <= p3_z1_r;
      p4_d21_r    <= p3_d21_r;
      p4_d31_r    <= p3_d31_r;
      p4_ca_hi_r  <= (2*W+1)'(p3_ph21_r[2*W:W]) * (2*W+1)'(p3_d31_r);
      p4_ca_lo_r  <= (2*W)'(p3_ph21_r[W-1:0]) * (2*W)'(p3_d31_r);
      p4_e3_hi_r  <= (2*W)'(p3_e2_r[2*W-1:W]) * (2*W)'(p3_e_r);
      p4_e3_lo_r  <= (2*W)'(p3_e2_r[W-1:0]) * (2*W)'(p3_e_r);
      p4_den1_r   <= (tdec_pkg::DEN_W'(p3_p2131_r) << 1) + tdec_pkg::DEN_W'(p3_p2131_r);
      p4_dp_r     <= (2*W+2)'(p3_d31_r) * (2*W+2)'(p3_t_r);
      p4_num2_r   <= p3_pa_r - (2*W+1)'(p3_p2131_r);
      p4_sq31_r   <= p3_sq31_r;
      p4_ax_r     <= p3_ax_r;
      p4_asum_r   <= p3_asum_r;
      p4_d31x3_r  <= p3_d31x3_r;
    end
  end

  // Stage 5: assemble the wide operands and load the iterative units.
  always_comb begin
    cube_full = ((3*W+1)'(p4_ca_hi_r) << W) + (3*W+1)'(p4_ca_lo_r);
    e3_full   = ((3*W+1)'(p4_e3_hi_r) << W) + (3*W+1)'(p4_e3_lo_r);
    disc_full = (2*SW+1)'(p4_sq31_r) + ((2*SW+1)'(p4_dp_r) << 2);
    p5_nxt             = '0;
    p5_nxt.side.cmd    = p4_cmd_r;
    p5_nxt.side.region = p4_region_r;
    p5_nxt.side.z1     = p4_z1_r;
    p5_nxt.side.v      = p4_v_r;
    p5_nxt.side.d21    = p4_d21_r;
    p5_nxt.side.d31    = p4_d31_r;
    p5_nxt.den         = tdec_pkg::DEN_W'(3);
    if (p4_cmd_r == tdec_pkg::CMD_D2E) begin
      p5_nxt.side.neg = p4_sneg_r;
      p5_nxt.rem      = tdec_pkg::NUM_W'(p4_asum_r);
      case (p4_region_r)
        tdec_pkg::REG_LOW: p5_nxt.c_arg = (3*W)'(cube_full);
        tdec_pkg::REG_MID: p5_nxt.s_arg = (2*SW)'(disc_full);
        default: ;
      endcase
    end else begin
      p5_nxt.side.neg = p4_neg3_r;
      case (p4_region_r)
        tdec_pkg::REG_WET: p5_nxt.rem = tdec_pkg::NUM_W'(p4_ax_r);
        tdec_pkg::REG_MID: begin
          p5_nxt.rem = tdec_pkg::NUM_W'(p4_num2_r);
          p5_nxt.den = tdec_pkg::DEN_W'(p4_d31x3_r);
        end
        tdec_pkg::REG_LOW: begin
          p5_nxt.rem = tdec_pkg::NUM_W'(e3_full);
          p5_nxt.den = p4_den1_r;
        end
        default: p5_nxt.den = tdec_pkg::DEN_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_s[0] <= p5_nxt;
    end
  end

  // Iterative stages: one quotient bit per stage, and one bit of each root in the stages its width covers.
  for (genvar j = 0; j < NS; j++) begin : g_iter
    tdec_iter_stage #(.STEP(j)) u_stage (
      .clk   (clk),
      .en    (adv),
      .d_in  (it_s[j]),
      .d_out (it_s[j+1])
    );
  end

  // Result stage: root clamps, quotient signs and saturation.
  assign last = it_s[NS];

  always_comb begin
    q_signed = last.side.neg ? -STW'(last.quo) : STW'(last.quo);
    cr_clamp = (last.c_root > last.side.d21) ? last.side.d21 : last.c_root;
    sq_s     = '0;
    if (last.s_root > SW'(last.side.d31)) begin
      sq_s = (last.s_root - SW'(last.side.d31)) >> 1;
    end
    if (sq_s < SW'(last.side.d21)) begin
      sq_s = SW'(last.side.d21);
    end
    if (sq_s > SW'(last.side.d31)) begin
      sq_s = SW'(last.side.d31);
    end
    res_nxt = '0;
    if (last.side.cmd == tdec_pkg::CMD_D2E) begin
      case (last.side.region)
        tdec_pkg::REG_DRY: res_nxt = last.side.z1;
        tdec_pkg::REG_LOW: res_nxt = last.side.z1 + cr_clamp;
        tdec_pkg::REG_MID: res_nxt = last.side.z1 + W'(sq_s);
        default: res_nxt = tdec_pkg::sat_word(STW'($signed(last.side.v)) + q_signed);
      endcase
    end else begin
      case (last.side.region)
        tdec_pkg::REG_WET: res_nxt = tdec_pkg::sat_word(q_signed);
        tdec_pkg::REG_MID, tdec_pkg::REG_LOW: begin
          if (last.quo > tdec_pkg::QUO_W'({(W-1){1'b1}})) begin
            res_nxt = {1'b0, {(W-1){1'b1}}};
          end else begin
            res_nxt = W'(last.quo);
          end
        end
        default: res_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= res_nxt;
      out_region_r <= last.side.region;
    end
    if (adv && vld_r[NST-1] && !out_ch.ready) begin
      skid_value_r  <= out_value_r;
      skid_region_r <= out_region_r;
    end
  end

  // Output side: the skid register goes first when it holds an item.
  assign out_ch.valid     = skid_full_r || vld_r[NST-1];
  assign out_ch.value_out = skid_full_r ? skid_value_r : out_value_r;
  assign out_ch.region    = skid_full_r ? skid_region_r : out_region_r;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the triangle cell depth/free-surface converter: a directed table followed by
// random cells, every result checked against a typed value or an in-bench model of the piecewise relation.
// Depends on tdec_pkg, tdec_if and the unit under test.
module tb_top;

  typedef logic [127:0] u128;

  typedef struct {
    logic              cmd;
    int                v;
    int                za;
    int                zb;
    int                zc;
    bit                typed;
    int                ev;
    tdec_pkg::region_t er;
  } cell_row_t;

  typedef struct {
    logic [31:0]       value;
    tdec_pkg::region_t region;
  } conv_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tdec_pkg::THR_W-1:0] cfg_wdata;

  tdec_in_if  in_ch ();
  tdec_out_if out_ch ();

  triangle_depth_elevation_convert_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  conv_t       pending_q[$];
  logic [15:0] thr_model;
  bit          quiet;
  int          fail_count;
  int          sent_count;
  int          checked_count;
  int          directed_count;
  int          idle_cycles;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor cube root of a wide value, one root bit at a time.
  function automatic u128 floor_cbrt(input u128 x);
    u128 r;
    u128 c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (u128'(1) << b);
      if (c * c * c <= x) r = c;
    end
    return r;
  endfunction

  // Floor square root of a wide value.
  function automatic u128 floor_sqrt(input u128 x);
    u128 r;
    u128 c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (u128'(1) << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic longint clamp_word(input longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  function automatic longint clamp_quotient(input u128 q);
    if (q > u128'(WMAX)) return WMAX;
    return longint'(q[63:0]);
  endfunction

  function automatic longint floor_third(input longint x);
    if (x >= 0) return x / 3;
    return -((-x + 2) / 3);
  endfunction

  // Expected result of one cell under the given dry threshold.
  function automatic conv_t convert_cell(input logic cmd, input int vin, input int za,
                                         input int zb, input int zc, input logic [15:0] thr);
    conv_t  o;
    longint v, z1, z2, z3, t, sum, h3, res;
    u128    d21, d31, lhs, sq21, disc, q, s, num;
    v = vin;
    z1 = za;
    z2 = zb;
    z3 = zc;
    if (z1 > z2) begin t = z1; z1 = z2; z2 = t; end
    if (z2 > z3) begin t = z2; z2 = z3; z3 = t; end
    if (z1 > z2) begin t = z1; z1 = z2; z2 = t; end
    d21 = u128'(z2 - z1);
    d31 = u128'(z3 - z1);
    sum = z1 + z2 + z3;
    res = 0;
    o.region = tdec_pkg::REG_DRY;
    if (cmd == tdec_pkg::CMD_D2E) begin
      if (v <= longint'(thr)) begin
        res = z1;
      end else begin
        h3 = 3 * v;
        lhs = u128'(h3) * d31;
        sq21 = d21 * d21;
        if (d21 > 0 && lhs <= sq21) begin
          q = floor_cbrt(u128'(h3) * d21 * d31);
          if (q > d21) q = d21;
          res = z1 + longint'(q[63:0]);
          o.region = tdec_pkg::REG_LOW;
        end else if (lhs > sq21 && u128'(h3) + d21 <= 2 * d31) begin
          disc = d31 * d31 + 4 * d31 * (d21 + u128'(h3));
          q = floor_sqrt(disc);
          s = '0;
          if (q > d31) s = (q - d31) >> 1;
          if (s < d21) s = d21;
          if (s > d31) s = d31;
          res = z1 + longint'(s[63:0]);
          o.region = tdec_pkg::REG_MID;
        end else begin
          res = clamp_word(v + floor_third(sum));
          o.region = tdec_pkg::REG_WET;
        end
      end
    end else begin
      if (v > z3) begin
        res = clamp_word((3 * v - sum) / 3);
        o.region = tdec_pkg::REG_WET;
      end else if (v > z2) begin
        s = u128'(v - z1);
        num = s * s + s * d31 - d31 * d21;
        res = clamp_quotient(num / (3 * d31));
        o.region = tdec_pkg::REG_MID;
      end else if (v > z1) begin
        s = u128'(v - z1);
        q = (s * s * s) / d21;
        res = clamp_quotient(q / (3 * d31));
        o.region = tdec_pkg::REG_LOW;
      end
    end
    o.value = res[31:0];
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Present one item and hold it until the unit takes it.
  task automatic send_cell(input cell_row_t row);
    conv_t e;
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= row.cmd;
    in_ch.value_in <= row.v;
    in_ch.z_low    <= row.za;
    in_ch.z_mid    <= row.zb;
    in_ch.z_high   <= row.zc;
    do @(posedge clk); while (!in_ch.ready);
    if (row.typed) begin
      e.value = row.ev;
      e.region = row.er;
    end else begin
      e = convert_cell(row.cmd, row.v, row.za, row.zb, row.zc, thr_model);
    end
    pending_q = {pending_q, e};
    sent_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model = val;
  endtask

  function automatic longint pick_between(input longint lo, input longint hi);
    longint unsigned r;
    if (hi <= lo) return lo;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  // Random cell: mostly sorted-range geometry with the value aimed at one region.
  function automatic cell_row_t random_cell();
    cell_row_t row;
    longint    base, d1, d2, zl, zm, zh, eta;
    int        zs[3];
    int        tmp, k;
    conv_t     back;
    row.typed = 1'b0;
    row.ev = 0;
    row.er = tdec_pkg::REG_DRY;
    row.cmd = $urandom_range(0, 1);
    if ($urandom_range(0, 9) == 0) begin
      row.v  = $urandom;
      row.za = $urandom;
      row.zb = $urandom;
      row.zc = $urandom;
      return row;
    end
    base = longint'(int'($urandom)) >>> $urandom_range(0, 16);
    d1 = longint'($urandom >> $urandom_range(4, 31));
    d2 = longint'($urandom >> $urandom_range(4, 31));
    if ($urandom_range(0, 15) == 0) d1 = 0;
    if ($urandom_range(0, 15) == 0) d2 = 0;
    zl = clamp_word(base);
    zm = clamp_word(zl + d1);
    zh = clamp_word(zm + d2);
    case ($urandom_range(0, 3))
      0: eta = pick_between(WMIN, zl);
      1: eta = pick_between(zl, zm);
      2: eta = pick_between(zm, zh);
      default: eta = pick_between(zh, clamp_word(zh + longint'($urandom >> 8)));
    endcase
    zs[0] = int'(zl);
    zs[1] = int'(zm);
    zs[2] = int'(zh);
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = zs[i];
      zs[i] = zs[k];
      zs[k] = tmp;
    end
    row.za = zs[0];
    row.zb = zs[1];
    row.zc = zs[2];
    if (row.cmd == tdec_pkg::CMD_E2D) begin
      row.v = int'(eta);
    end else begin
      back = convert_cell(tdec_pkg::CMD_E2D, int'(eta), zs[0], zs[1], zs[2], thr_model);
      row.v = int'(clamp_word(longint'(signed'(back.value)) +
                              longint'($urandom_range(0, 4)) - 2));
    end
    return row;
  endfunction

  // Result side: random backpressure, quiet during the no-idle stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 12);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    conv_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", out_ch.value_out, 32'h0);
      end else begin
        e = pending_q.pop_front();
        checked_count++;
        if (out_ch.value_out !== e.value) report("value_out", out_ch.value_out, e.value);
        if (out_ch.region !== e.region) report("region", 32'(out_ch.region), 32'(e.region));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_q.size());
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    cell_row_t table_rows[$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = tdec_pkg::CMD_D2E;
    in_ch.value_in = '0;
    in_ch.z_low = '0;
    in_ch.z_mid = '0;
    in_ch.z_high = '0;
    thr_model = 16'd1;
    quiet = 1'b0;
    fail_count = 0;
    sent_count = 0;
    checked_count = 0;
    idle_cycles = 0;

    // Directed rows: typed results where they follow directly, the rest predicted.
    table_rows = '{
      '{tdec_pkg::CMD_D2E, 0, 0, 65536, 131072, 1, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 1, 5, 3, -7, 1, -7, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 32'sh80000000, 100, -100, 0, 1, -100, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 32'sh80000000, 0, 1, 2, 1, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, -65536, -65536, 0, 65536, 1, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
        1, 32'sh7fffffff, tdec_pkg::REG_WET},
      '{tdec_pkg::CMD_D2E, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
        1, 32'sh7fffffff, tdec_pkg::REG_WET},
      '{tdec_pkg::CMD_D2E, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
        1, -1, tdec_pkg::REG_WET},
      '{tdec_pkg::CMD_D2E, 2, 0, 0, 0, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 65536, 0, 0, 0, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 4000, 0, 65536, 131072, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 40000, 131072, 0, 65536, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 30000, 0, 65536, 131072, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 100000, 65536, 131072, 0, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 0, 32'sh80000000, 0, 32'sh7fffffff, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 32'sh7ffffff0, 32'sh80000000, 0, 32'sh7fffffff, 0, 0,
        tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 32'sh40000000, 32'sh80000000, 0, 32'sh7fffffff, 0, 0,
        tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
        0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_E2D, 5, 0, 0, 10, 0, 0, tdec_pkg::REG_DRY},
      '{tdec_pkg::CMD_D2E, 3, 0, 10, 10, 0, 0, tdec_pkg::REG_DRY}
    };
    directed_count = table_rows.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_cell(table_rows[i]);

    // Threshold zero: no positive depth is dry.
    set_threshold(16'd0);
    for (int n = 0; n < 300; n++) send_cell(random_cell());

    // Largest threshold, a quiet stretch and one full drain in the middle.
    set_threshold(16'hffff);
    for (int n = 0; n < 300; n++) begin
      quiet = (n >= 100 && n < 200);
      if (n == 150) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      send_cell(random_cell());
    end
    quiet = 1'b0;

    set_threshold(16'($urandom));
    for (int n = 0; n < 300; n++) send_cell(random_cell());

    wait_drained();
    $display("sent %0d cells (%0d directed) over four thresholds, checked %0d results",
             sent_count, directed_count, checked_count);
    $display("%0d mismatches", fail_count);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
